[rtl/nvi_pkg.sv]
// Package for the Neville interpolation block: sizes, status codes, FSM states
// and the command/status structs between controller and datapath.
// No dependencies.
package nvi_pkg;

  localparam int MAX_NODES = 16;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;            // q - x, x - x
  localparam int PROD_W    = DIFF_W + DATA_W;       // exact numerator magnitude
  localparam int DIVC_W    = $clog2(PROD_W + 1);

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NONODE = 3'd1,
    ST_DUP    = 3'd2,
    ST_SAT    = 3'd3,
    ST_DROP   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DUP_RD,
    S_DUP_CMP,
    S_CP_RD,
    S_CP_WR,
    S_UPD_RD,
    S_UPD_MUL,
    S_UPD_SUM,
    S_UPD_DIV,
    S_UPD_WB,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic dup_phase;
    logic dup_next;
    logic cp_wr;
    logic mul_en;
    logic div_start;
    logic wb;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic dup_eq;
    logic dup_last;
    logic cp_last;
    logic upd_last;
    logic div_done;
    logic sat;
    logic excess;
  } dp_stat_t;

endpackage

[rtl/neville_interpolation.sv]
// Neville polynomial interpolation engine, signed Q16.16 fixed point.
// Top level: nvi_ctrl + nvi_datapath (with nvi_div); depends on nvi_pkg.
//
// Usage:
//   A transaction is taken on a rising edge with start high and busy low.
//   in_mode = 0 stores node (in_node_x, in_node_y); in_start_new empties the
//   list first. Up to 16 nodes; further loads are dropped and flagged.
//   A load produces no result; busy stays low.
//   in_mode = 1 evaluates the polynomial through the stored nodes at
//   in_query_x and gives one result on out_value/out_status, valid for the
//   single cycle in which out_strobe is high.
// Sequence of an evaluate with n nodes: an empty list goes straight to the
//   result; otherwise each node pair is checked for duplicate x with a read
//   and a compare (n*(n-1)/2 pairs, stops early on a match), each node is
//   copied with a read and a write, n*(n-1)/2 Neville updates follow, then
//   the result. An update is a read, the two 33x32 multiplies, the numerator
//   add, the bit-serial divide and a write-back. The next transaction is
//   taken after the strobe.
// Status: 0 ok, 1 no nodes, 2 duplicate x, 3 saturated, 4 nodes dropped.
// Reset clears node count, dropped flag and the controller; node data is
// undefined until loaded. The receiver cannot stall: results are never held.
module neville_interpolation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic signed [31:0] in_node_x,
  input  logic signed [31:0] in_node_y,
  input  logic               in_start_new,
  input  logic signed [31:0] in_query_x,
  output logic               out_strobe,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);
  import nvi_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      res_ok;

  nvi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_mode    (in_mode),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_status (out_status),
    .res_ok     (res_ok)
  );

  nvi_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_start_new (in_start_new),
    .in_node_x    (in_node_x),
    .in_node_y    (in_node_y),
    .in_query_x   (in_query_x),
    .res_ok       (res_ok),
    .stat         (stat),
    .out_value    (out_value)
  );

`ifndef SYNTHESIS
  // a load never produces a result or makes the block busy
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_mode) |=> (!busy && !out_strobe))
    else $error("load transaction left block busy");
  // an evaluate always occupies the block
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |=> busy)
    else $error("evaluate not started");
  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_NONODE || out_status == ST_DUP)) |-> (out_value == 0))
    else $error("error result with nonzero value");
  // strobe lasts one cycle and is followed by idle
  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (!out_strobe && !busy))
    else $error("strobe not followed by idle");
`endif

endmodule

[rtl/nvi_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nvi_pkg.
module nvi_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nvi_pkg::PROD_W-1:0]  dividend,
  input  logic [nvi_pkg::DIFF_W-1:0]  divisor,
  output logic                        done,
  output logic [nvi_pkg::PROD_W-1:0]  quotient
);
  import nvi_pkg::*;

  logic [DIFF_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [DIFF_W-1:0] dvs_r;
  logic [DIVC_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt, done_r, done_nxt;
  logic [DIFF_W:0]   trial;

  always_comb begin
    trial    = {rem_r, quo_r[PROD_W-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIFF_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIFF_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DIVC_W'(1);
      if (cnt_r == DIVC_W'(PROD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/nvi_datapath.sv]
// Node/work memories, loop counters, Neville update arithmetic and result value.
// Depends on nvi_pkg and nvi_div.
module nvi_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  nvi_pkg::ctrl_cmd_t        cmd,
  input  logic                      in_start_new,
  input  logic signed [31:0]        in_node_x,
  input  logic signed [31:0]        in_node_y,
  input  logic signed [31:0]        in_query_x,
  input  logic                      res_ok,
  output nvi_pkg::dp_stat_t         stat,
  output logic signed [31:0]        out_value
);
  import nvi_pkg::*;

  logic [DATA_W-1:0] x_mem [MAX_NODES];
  logic [DATA_W-1:0] y_mem [MAX_NODES];
  logic [DATA_W-1:0] w_mem [MAX_NODES];

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_m1;
  logic             excess_r, excess_nxt;
  logic [IDX_W-1:0] a_r, b_r, k_r, i_r, j_r;
  logic signed [DATA_W-1:0] q_r;
  logic             sat_r;
  logic [DATA_W-1:0] last_r;

  logic [IDX_W-1:0]  xa_addr, xb_addr;
  logic [DATA_W-1:0] xa_rd, xb_rd, y_rd, wa_rd, wb_rd;
  logic              w_we;
  logic [IDX_W-1:0]  w_addr;
  logic [DATA_W-1:0] w_din;

  // load
  logic [CNT_W-1:0] base;
  always_comb begin
    base       = in_start_new ? '0 : cnt_r;
    cnt_nxt    = cnt_r;
    excess_nxt = excess_r;
    if (cmd.load) begin
      if (in_start_new) excess_nxt = 1'b0;
      if (base < CNT_W'(MAX_NODES)) cnt_nxt = base + CNT_W'(1);
      else begin
        cnt_nxt    = base;
        excess_nxt = 1'b1;
      end
    end
  end

  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign xa_addr = cmd.dup_phase ? a_r : j_r;
  assign xb_addr = cmd.dup_phase ? b_r : IDX_W'(j_r + i_r);

  always_ff @(posedge clk) begin
    if (cmd.load && base < CNT_W'(MAX_NODES)) begin
      x_mem[base[IDX_W-1:0]] <= in_node_x;
      y_mem[base[IDX_W-1:0]] <= in_node_y;
    end
    xa_rd <= x_mem[xa_addr];
    xb_rd <= x_mem[xb_addr];
    y_rd  <= y_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_addr] <= w_din;
    wa_rd <= w_mem[j_r];
    wb_rd <= w_mem[IDX_W'(j_r + IDX_W'(1))];
  end

  // arithmetic: products, then numerator, then divide
  logic signed [DIFF_W-1:0] dqb, dqa, dx;
  logic [DIFF_W-1:0] mqb, mqa, mdx;
  logic [DATA_W-1:0] mpa, mpb;
  logic [PROD_W-1:0] m1_r, m2_r, mn;
  logic              n1_r, n2_r, nd_r, nn_r, nn;
  logic [DIFF_W-1:0] md_r;
  logic              div_done;
  logic [PROD_W-1:0] quo;

  always_comb begin
    dqb = DIFF_W'(q_r) - DIFF_W'($signed(xb_rd));
    dqa = DIFF_W'(q_r) - DIFF_W'($signed(xa_rd));
    dx  = DIFF_W'($signed(xa_rd)) - DIFF_W'($signed(xb_rd));
    mqb = dqb[DIFF_W-1] ? DIFF_W'(-dqb) : dqb;
    mqa = dqa[DIFF_W-1] ? DIFF_W'(-dqa) : dqa;
    mdx = dx[DIFF_W-1]  ? DIFF_W'(-dx)  : dx;
    mpa = wa_rd[DATA_W-1] ? DATA_W'(-wa_rd) : wa_rd;
    mpb = wb_rd[DATA_W-1] ? DATA_W'(-wb_rd) : wb_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      m1_r <= PROD_W'(mqb) * PROD_W'(mpa);
      m2_r <= PROD_W'(mqa) * PROD_W'(mpb);
      n1_r <= dqb[DIFF_W-1] ^ wa_rd[DATA_W-1];
      n2_r <= ~(dqa[DIFF_W-1] ^ wb_rd[DATA_W-1]);
      md_r <= mdx;
      nd_r <= dx[DIFF_W-1];
    end
  end

  always_comb begin
    if (n1_r == n2_r) begin
      mn = m1_r + m2_r;
      nn = n1_r;
    end else if (m1_r >= m2_r) begin
      mn = m1_r - m2_r;
      nn = n1_r;
    end else begin
      mn = m2_r - m1_r;
      nn = n2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) nn_r <= nn;
  end

  nvi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mn),
    .divisor  (md_r),
    .done     (div_done),
    .quotient (quo)
  );

  // sign and clamp
  logic              nq, sat_cur;
  logic [DATA_W-1:0] upd_val;
  always_comb begin
    nq      = (nn_r != nd_r) && (quo != '0);
    sat_cur = 1'b0;
    if (nq) begin
      if (quo > PROD_W'(64'h8000_0000)) begin
        sat_cur = 1'b1;
        upd_val = 32'h8000_0000;
      end else begin
        upd_val = DATA_W'(-quo[DATA_W-1:0]);
      end
    end else if (quo > PROD_W'(64'h7FFF_FFFF)) begin
      sat_cur = 1'b1;
      upd_val = 32'h7FFF_FFFF;
    end else begin
      upd_val = quo[DATA_W-1:0];
    end
  end

  assign w_we   = cmd.cp_wr | cmd.wb;
  assign w_addr = cmd.cp_wr ? k_r : j_r;
  assign w_din  = cmd.cp_wr ? y_rd : upd_val;

  // counters and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      excess_r <= 1'b0;
      sat_r    <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      excess_r <= excess_nxt;
      if (cmd.capture) sat_r <= 1'b0;
      else if (cmd.wb && sat_cur) sat_r <= 1'b1;
    end
    if (cmd.capture) begin
      q_r <= in_query_x;
      a_r <= '0;
      b_r <= IDX_W'(1);
      k_r <= '0;
      i_r <= IDX_W'(1);
      j_r <= '0;
    end
    if (cmd.dup_next) begin
      if ({1'b0, b_r} == cnt_m1) begin
        a_r <= a_r + IDX_W'(1);
        b_r <= a_r + IDX_W'(2);
      end else begin
        b_r <= b_r + IDX_W'(1);
      end
    end
    if (cmd.cp_wr) k_r <= k_r + IDX_W'(1);
    if (cmd.wb) begin
      if (CNT_W'(j_r) + CNT_W'(i_r) == cnt_m1) begin
        i_r <= i_r + IDX_W'(1);
        j_r <= '0;
      end else begin
        j_r <= j_r + IDX_W'(1);
      end
    end
    if (w_we) last_r <= w_din;
  end

  always_comb begin
    stat.cnt_zero = (cnt_r == '0);
    stat.cnt_one  = (cnt_r == CNT_W'(1));
    stat.dup_eq   = (xa_rd == xb_rd);
    stat.dup_last = ({1'b0, b_r} == cnt_m1) && (CNT_W'(a_r) + CNT_W'(2) == cnt_r);
    stat.cp_last  = ({1'b0, k_r} == cnt_m1);
    stat.upd_last = ({1'b0, i_r} == cnt_m1);
    stat.div_done = div_done;
    stat.sat      = sat_r | (cmd.wb & sat_cur);
    stat.excess   = excess_r;
  end

  assign out_value = res_ok ? $signed(last_r) : 32'sd0;

endmodule

[rtl/nvi_ctrl.sv]
// Controller FSM sequencing duplicate check, copy and Neville updates.
// Depends on nvi_pkg.
module nvi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_mode,
  input  nvi_pkg::dp_stat_t   stat,
  output nvi_pkg::ctrl_cmd_t  cmd,
  output logic                busy,
  output logic                out_strobe,
  output logic [2:0]          out_status,
  output logic                res_ok
);
  import nvi_pkg::*;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;
  status_t fin_code;

  assign fin_code = stat.sat ? ST_SAT : (stat.excess ? ST_DROP : ST_OK);

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    case (state_r)
      S_IDLE: begin
        if (start && in_mode) begin
          if (stat.cnt_zero) begin
            state_nxt = S_OUT;
            code_nxt  = ST_NONODE;
          end else if (stat.cnt_one) state_nxt = S_CP_RD;
          else state_nxt = S_DUP_RD;
        end
      end
      S_DUP_RD:  state_nxt = S_DUP_CMP;
      S_DUP_CMP: begin
        if (stat.dup_eq) begin
          state_nxt = S_OUT;
          code_nxt  = ST_DUP;
        end else if (stat.dup_last) state_nxt = S_CP_RD;
        else state_nxt = S_DUP_RD;
      end
      S_CP_RD: state_nxt = S_CP_WR;
      S_CP_WR: begin
        if (!stat.cp_last) state_nxt = S_CP_RD;
        else if (stat.cnt_one) begin
          state_nxt = S_OUT;
          code_nxt  = fin_code;
        end else state_nxt = S_UPD_RD;
      end
      S_UPD_RD:  state_nxt = S_UPD_MUL;
      S_UPD_MUL: state_nxt = S_UPD_SUM;
      S_UPD_SUM: state_nxt = S_UPD_DIV;
      S_UPD_DIV: if (stat.div_done) state_nxt = S_UPD_WB;
      S_UPD_WB: begin
        if (stat.upd_last) begin
          state_nxt = S_OUT;
          code_nxt  = fin_code;
        end else state_nxt = S_UPD_RD;
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    busy       = 1'b1;
    out_strobe = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.load    = start & ~in_mode;
        cmd.capture = start & in_mode;
      end
      S_DUP_RD:  cmd.dup_phase = 1'b1;
      S_DUP_CMP: begin
        cmd.dup_phase = 1'b1;
        cmd.dup_next  = ~stat.dup_eq & ~stat.dup_last;
      end
      S_CP_WR:   cmd.cp_wr     = 1'b1;
      S_UPD_MUL: cmd.mul_en    = 1'b1;
      S_UPD_SUM: cmd.div_start = 1'b1;
      S_UPD_WB:  cmd.wb        = 1'b1;
      S_OUT:     out_strobe    = 1'b1;
      default:   busy          = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
    code_r <= code_nxt;
  end

  assign out_status = code_r;
  assign res_ok     = (code_r == ST_OK) || (code_r == ST_SAT) || (code_r == ST_DROP);

endmodule

[bench/neville_interpolation_tb.sv]
// Self-checking bench for neville_interpolation: directed table, then random node lists.
// Expected values come from a local Neville predictor. Depends on nvi_pkg and the RTL.
module neville_interpolation_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nvi_pkg::*;

  // Clock, reset and DUT ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_mode = 1'b0;
  logic signed [31:0] in_node_x = '0;
  logic signed [31:0] in_node_y = '0;
  logic               in_start_new = 1'b0;
  logic signed [31:0] in_query_x = '0;
  logic               out_strobe;
  logic signed [31:0] out_value;
  logic [2:0]         out_status;

  localparam int STALL_LIMIT = 60000;  // well above the worst evaluate
  localparam int ITEM_GOAL   = 1050;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  neville_interpolation uut (
    .clk, .rst_n, .start, .busy, .in_mode, .in_node_x, .in_node_y,
    .in_start_new, .in_query_x, .out_strobe, .out_value, .out_status
  );

  // One pending evaluate result
  typedef struct {
    logic [31:0] value;
    status_t     status;
  } eval_result_t;

  eval_result_t pending_evals[$];

  // Predictor state: node list, count and dropped flag
  longint node_xs[MAX_NODES];
  longint node_ys[MAX_NODES];
  int     node_cnt;
  bit     nodes_dropped;

  int errors = 0;
  int items_sent;
  int stall_cnt = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [64:0] magn(input longint v);
    return (v < 0) ? 65'(-v) : 65'(v);
  endfunction

  // One recurrence step: ((q-xb)*pa - (q-xa)*pb) / (xa-xb), truncated, clamped
  function automatic longint neville_term(input longint q, xa, xb, pa, pb,
                                          inout bit sat);
    logic [64:0] m1, m2, mn, md, quo;
    bit n1, n2, nn, nd;
    m1 = magn(q - xb) * magn(pa);
    n1 = ((q - xb) < 0) ^ (pa < 0);
    m2 = magn(q - xa) * magn(pb);
    n2 = !(((q - xa) < 0) ^ (pb < 0));   // subtracted term
    if (n1 == n2) begin
      mn = m1 + m2;
      nn = n1;
    end else if (m1 >= m2) begin
      mn = m1 - m2;
      nn = n1;
    end else begin
      mn = m2 - m1;
      nn = n2;
    end
    md  = magn(xa - xb);
    nd  = (xa - xb) < 0;
    quo = mn / md;
    if (nn != nd && quo != 0) begin
      if (quo > 65'd2147483648) begin
        sat = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(quo);
    end
    if (quo > 65'd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(quo);
  endfunction

  function automatic eval_result_t predict_value(input longint q);
    eval_result_t r;
    longint work[MAX_NODES];
    bit sat;
    sat = 1'b0;
    r.value = '0;
    if (node_cnt == 0) begin
      r.status = ST_NONODE;
      return r;
    end
    // duplicate abscissa check precedes arithmetic
    for (int a = 0; a < node_cnt; a++)
      for (int b = a + 1; b < node_cnt; b++)
        if (node_xs[a] == node_xs[b]) begin
          r.status = ST_DUP;
          return r;
        end
    for (int i = 0; i < node_cnt; i++) work[i] = node_ys[i];
    for (int i = 1; i < node_cnt; i++)
      for (int j = 0; j + i < node_cnt; j++)
        work[j] = neville_term(q, node_xs[j], node_xs[j+i], work[j], work[j+1], sat);
    r.value  = work[0][31:0];
    r.status = sat ? ST_SAT : (nodes_dropped ? ST_DROP : ST_OK);
    return r;
  endfunction

  // Drive one transaction after a random gap; update the predictor on acceptance.
  // A directed row may carry its expected result, which then replaces the prediction.
  task automatic send_item(input bit m, input logic [31:0] x, y, input bit sn,
                           input logic [31:0] q, input bit has_exp = 1'b0,
                           input logic [31:0] exp_val = '0,
                           input status_t exp_st = ST_OK);
    int gap;
    eval_result_t r;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 9) < 4) gap = 0;   // back-to-back stretches
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_mode      <= m;
    in_node_x    <= x;
    in_node_y    <= y;
    in_start_new <= sn;
    in_query_x   <= q;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    if (!m) begin
      if (sn) begin
        node_cnt      = 0;
        nodes_dropped = 1'b0;
      end
      if (node_cnt < MAX_NODES) begin
        node_xs[node_cnt] = longint'($signed(x));
        node_ys[node_cnt] = longint'($signed(y));
        node_cnt++;
      end else begin
        nodes_dropped = 1'b1;
      end
    end else begin
      r = predict_value(longint'($signed(q)));
      if (has_exp) begin
        r.value  = exp_val;
        r.status = exp_st;
      end
      pending_evals.insert(pending_evals.size(), r);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_evals.size() != 0);
  endtask

  // Result checker: strobe is a one-cycle pulse, sampled on the edge that ends it
  always @(posedge clk) begin
    eval_result_t e;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_evals.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h status=%0d",
                                  out_value, out_status));
      end else begin
        e = pending_evals.pop_front();
        if (out_value !== e.value)
          report_mismatch($sformatf("value %h, predicted %h", out_value, e.value));
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d, predicted %0d", out_status, e.status));
      end
    end
  end

  // Watchdog: cycles with neither an accepted transaction nor a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog expired");
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Directed table: rows with rep > 1 load rep nodes at the row's x plus k * 1.0
  typedef struct {
    bit          m;
    logic [31:0] x, y;
    bit          sn;
    logic [31:0] q;
    int          rep;
    bit          has_exp;
    logic [31:0] ev;
    status_t     es;
  } stim_row_t;

  stim_row_t dir_rows[$];

  function automatic void add_row(input stim_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  initial begin
    int n, evals, style, step;
    logic [31:0] x, y, q, base;
    items_sent = 0;
    node_cnt = 0;
    nodes_dropped = 1'b0;

    // empty list, then single node
    add_row('{1, 32'h0, 32'h0, 0, 32'h0, 1, 1, 32'h0, ST_NONODE});
    add_row('{0, 32'h0, 32'h7fffffff, 1, 32'hffffffff, 1, 0, 0, ST_OK});
    add_row('{1, 32'h0, 32'h0, 0, 32'h80000000, 1, 1, 32'h7fffffff, ST_OK});
    // field extremes, two and three nodes
    add_row('{0, 32'h80000000, 32'h80000000, 1, 32'h0, 1, 0, 0, ST_OK});
    add_row('{0, 32'h7fffffff, 32'h7fffffff, 0, 32'h0, 1, 0, 0, ST_OK});
    add_row('{1, 32'hffffffff, 32'hffffffff, 1, 32'h80000000, 1, 0, 0, ST_OK});
    add_row('{1, 32'h0, 32'h0, 0, 32'h7fffffff, 1, 0, 0, ST_OK});
    add_row('{0, 32'h0, 32'h1234, 0, 32'h0, 1, 0, 0, ST_OK});
    add_row('{1, 32'h0, 32'h0, 0, 32'h00010000, 1, 0, 0, ST_OK});
    // repeated abscissa
    add_row('{0, 32'h00050000, 32'h1, 1, 32'h0, 1, 0, 0, ST_OK});
    add_row('{0, 32'h00050000, 32'h2, 0, 32'h0, 1, 0, 0, ST_OK});
    add_row('{1, 32'h0, 32'h0, 0, 32'h00030000, 1, 1, 32'h0, ST_DUP});
    // saturation: steep line pushed far out
    add_row('{0, 32'h0, 32'h7fffffff, 1, 32'h0, 1, 0, 0, ST_OK});
    add_row('{0, 32'h1, 32'h80000000, 0, 32'h0, 1, 0, 0, ST_OK});
    add_row('{1, 32'h0, 32'h0, 0, 32'h7fffffff, 1, 0, 0, ST_OK});
    add_row('{1, 32'h0, 32'h0, 0, 32'h80000000, 1, 0, 0, ST_OK});
    // full list: 17 loads on a line (raw y = whole part of x), one dropped;
    // at x = 2.0 the line gives raw 2 exactly
    add_row('{0, 32'h0, 32'h0, 1, 32'h0, 17, 0, 0, ST_OK});
    add_row('{1, 32'h0, 32'h0, 0, 32'h00020000, 1, 1, 32'h2, ST_DROP});
    // saturation outranks dropped nodes
    add_row('{0, 32'h7fffffff, 32'h7fffffff, 1, 32'h0, 17, 0, 0, ST_OK});
    add_row('{1, 32'h0, 32'h0, 0, 32'h80000000, 1, 0, 0, ST_OK});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].rep; k++) begin
        x = (dir_rows[i].rep > 1) ? (dir_rows[i].x + (k << 16)) : dir_rows[i].x;
        y = (dir_rows[i].rep > 1) ? (dir_rows[i].y ^ k) : dir_rows[i].y;
        send_item(dir_rows[i].m, x, y, (k == 0) ? dir_rows[i].sn : 1'b0,
                  dir_rows[i].q, dir_rows[i].has_exp, dir_rows[i].ev, dir_rows[i].es);
      end
    end

    // hold off until the pipeline is empty at least once
    drain_results();

    // Random node lists: mostly short, a few full or overflowing
    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 49))
        0, 1:             n = $urandom_range(17, 19);
        2, 3, 4, 5:       n = $urandom_range(11, 16);
        6, 7, 8, 9, 10,
        11, 12, 13, 14:   n = $urandom_range(6, 10);
        default:          n = $urandom_range(1, 5);
      endcase
      style = $urandom_range(0, 3);
      step  = $urandom_range(1, 3);
      base  = ($urandom_range(0, 40) - 20) << 16;
      for (int k = 0; k < n; k++) begin
        if (style == 0) begin
          x = $urandom();
          y = $urandom();
        end else begin
          x = base + ((k * step) << 16) + $urandom_range(0, 255);
          y = (style == 1) ? $urandom() : ($urandom_range(0, 4000) - 2000) << 8;
        end
        // occasional repeated abscissa
        if (k > 0 && $urandom_range(0, 19) == 0 && node_cnt > 0)
          x = node_xs[$urandom_range(0, node_cnt - 1)][31:0];
        // mostly fresh lists, sometimes append to what is stored
        send_item(1'b0, x, y, (k == 0) ? ($urandom_range(0, 4) != 0) : 1'b0,
                  $urandom());
      end
      evals = $urandom_range(1, 3);
      repeat (evals) begin
        q = ($urandom_range(0, 1) == 0) ? $urandom()
                                        : base + ($urandom_range(0, 12 << 16));
        send_item(1'b1, $urandom(), $urandom(), $urandom_range(0, 1), q);
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_evals.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
